// ===== rtl/cst_pkg.sv =====
package cst_pkg;

  localparam int CAPACITY = 16;
  localparam int VALUE_W  = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

// ===== rtl/compacting_set_table.sv =====
// Compacting set table: a packed table of up to 16 distinct 16-bit values.
// Input channel (in_valid / in_stall) carries one beat per operation:
//   in_kind 0 insert, 1 delete, 2 lookup (3 behaves as lookup), in_value.
// Result channel (out_valid / out_stall) returns one beat per operation:
//   membership before the operation, count after it, full/empty flags and
//   a dropped flag for a new insert refused because the table was full.
// A taken beat is held in input registers and its result is registered in the
//   execute step. The controller takes a beat, then runs the parallel compare
//   and the table update in that step; no new beat is taken until it ends.
// All entries are compared at once; a delete shifts the later entries
//   down one place in the same cycle.
// The result sits in an output register, so the next input beat is taken
//   while a result waits. If out_stall holds, the following operation waits
//   in the execute step until the result register is freed.
// Reset (rst_n low, synchronous) empties the set and drops any pending
//   result; table contents are not cleared since only live slots are read.
module compacting_set_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_kind,
  input  logic [cst_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_was_member,
  output logic [cst_pkg::CNT_W-1:0]     out_count_now,
  output logic                          out_is_full,
  output logic                          out_is_empty,
  output logic                          out_dropped
);

  cst_pkg::cmd_t  cmd;
  cst_pkg::stat_t stat;

  cst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cst_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_kind        (in_kind),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_was_member (out_was_member),
    .out_count_now  (out_count_now),
    .out_is_full    (out_is_full),
    .out_is_empty   (out_is_empty),
    .out_dropped    (out_dropped)
  );

endmodule

// ===== rtl/cst_ctrl.sv =====
module cst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cst_pkg::stat_t    stat,
  output cst_pkg::cmd_t     cmd
);

  cst_pkg::state_t state_r;
  cst_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cst_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cst_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = cst_pkg::ST_EXEC;
      end
      cst_pkg::ST_EXEC: begin
        // hold until the result register can take the new beat
        if (!stat.out_busy) state_nxt = cst_pkg::ST_IDLE;
      end
      default: state_nxt = cst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd.load_in  = 1'b0;
    cmd.exec     = 1'b0;
    case (state_r)
      cst_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      cst_pkg::ST_EXEC: begin
        cmd.exec = !stat.out_busy;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/cst_datapath.sv =====
module cst_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cst_pkg::cmd_t                 cmd,
  output cst_pkg::stat_t                stat,
  input  logic [1:0]                    in_kind,
  input  logic [cst_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_was_member,
  output logic [cst_pkg::CNT_W-1:0]     out_count_now,
  output logic                          out_is_full,
  output logic                          out_is_empty,
  output logic                          out_dropped
);

  cst_pkg::kind_t                kind_r;
  logic [cst_pkg::VALUE_W-1:0]   value_r;
  logic [cst_pkg::VALUE_W-1:0]   entries_r [cst_pkg::CAPACITY];
  logic [cst_pkg::CNT_W-1:0]     count_r;
  logic [cst_pkg::CNT_W-1:0]     count_nxt;

  logic                          out_valid_r;
  logic                          was_member_r;
  logic                          is_full_r;
  logic                          is_empty_r;
  logic                          dropped_r;

  logic [cst_pkg::CAPACITY-1:0]  hit;
  logic                          member;
  logic [cst_pkg::IDX_W-1:0]     slot;
  logic                          full;
  logic                          do_insert;
  logic                          do_delete;
  logic                          drop;

  // compare every live entry in parallel
  always_comb begin
    slot = '0;
    for (int i = 0; i < cst_pkg::CAPACITY; i++) begin
      hit[i] = (cst_pkg::CNT_W'(i) < count_r) && (entries_r[i] == value_r);
      if (hit[i]) slot = slot | cst_pkg::IDX_W'(i);
    end
  end

  assign member = |hit;
  assign full   = (count_r == cst_pkg::CNT_W'(cst_pkg::CAPACITY));

  always_comb begin
    do_insert = 1'b0;
    do_delete = 1'b0;
    drop      = 1'b0;
    case (kind_r)
      cst_pkg::KIND_INSERT: begin
        do_insert = !member && !full;
        drop      = !member && full;
      end
      cst_pkg::KIND_DELETE: begin
        do_delete = member;
      end
      default: begin
        do_insert = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (do_insert) count_nxt = count_r + cst_pkg::CNT_W'(1);
    else if (do_delete) count_nxt = count_r - cst_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r  <= cst_pkg::kind_t'(in_kind);
      value_r <= in_value;
    end
  end

  // append at the tail, or close the gap left by a delete
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < cst_pkg::CAPACITY; i++) begin
        if (do_insert && (count_r == cst_pkg::CNT_W'(i))) begin
          entries_r[i] <= value_r;
        end else if (do_delete && (i < cst_pkg::CAPACITY - 1) &&
                     (cst_pkg::IDX_W'(i) >= slot)) begin
          entries_r[i] <= entries_r[(i < cst_pkg::CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      was_member_r <= member;
      is_full_r    <= (count_nxt == cst_pkg::CNT_W'(cst_pkg::CAPACITY));
      is_empty_r   <= (count_nxt == '0);
      dropped_r    <= drop;
    end
  end

  assign stat.out_busy  = out_valid_r && out_stall;
  assign out_valid      = out_valid_r;
  assign out_was_member = was_member_r;
  assign out_count_now  = count_r;
  assign out_is_full    = is_full_r;
  assign out_is_empty   = is_empty_r;
  assign out_dropped    = dropped_r;

endmodule
